[hw/rtl/mtc_pkg.sv]
// Shared types and constants for the countdown timer table.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_UPDATE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        KIND_FIRED     = 4'd0,
        KIND_TICK_DONE = 4'd1,
        KIND_ADDED     = 4'd2,
        KIND_REPLACED  = 4'd3,
        KIND_DELETED   = 4'd4,
        KIND_UPDATED   = 4'd5,
        KIND_NOT_FOUND = 4'd6,
        KIND_ID_ZERO   = 4'd7,
        KIND_FULL      = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] countdown;
        logic [31:0] reload;
        logic [7:0]  handler;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic zero_id;
        logic table_empty;
        logic scan_last;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/mtc_ctrl.sv]
// Controller state machine sequencing load, table scan and final word.
`timescale 1ns / 1ps
`default_nettype none

module mtc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mtc_pkg::status_t  status,
    output mtc_pkg::cmd_t     cmd,
    output logic              busy
);

    mtc_pkg::state_t state_reg;
    mtc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (status.zero_id || status.table_empty)
                    begin
                        state_next = mtc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mtc_pkg::ST_SCAN;
                    end
                end
            end
            mtc_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = mtc_pkg::ST_FINISH;
                end
            end
            mtc_pkg::ST_FINISH:
            begin
                state_next = mtc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            mtc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                cmd.load = start;
            end
            mtc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            mtc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/mtc_dp.sv]
// Datapath: timer table, compacting scan pointers and result registers.
`timescale 1ns / 1ps
`default_nettype none

module mtc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mtc_pkg::cmd_t       cmd,
    output mtc_pkg::status_t    status,
    input  logic [1:0]          func,
    input  logic signed [15:0]  timer_id,
    input  logic signed [31:0]  time_value,
    input  logic                periodic,
    input  logic [7:0]          handler_tag,
    input  logic signed [31:0]  arg_a,
    input  logic signed [31:0]  arg_b,
    input  logic [15:0]         elapsed_ms,
    output logic                result_valid,
    output logic [3:0]          kind,
    output logic signed [15:0]  fired_id,
    output logic [7:0]          fired_handler,
    output logic signed [31:0]  fired_arg_a,
    output logic signed [31:0]  fired_arg_b,
    output logic                last
);

    localparam int IDX_W = mtc_pkg::IDX_W;
    localparam int CNT_W = mtc_pkg::CNT_W;

    mtc_pkg::entry_t tbl_mem [mtc_pkg::TABLE_DEPTH];

    mtc_pkg::func_t     func_reg;
    logic [15:0]        id_reg;
    logic [31:0]        tv_reg;
    logic               per_reg;
    logic [7:0]         tag_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [15:0]        el_reg;
    logic               zero_reg;
    logic               found_reg;
    logic               found_next;
    logic [IDX_W-1:0]   rd_reg;
    logic [IDX_W-1:0]   rd_ahead;
    logic [CNT_W-1:0]   wr_reg;
    logic [CNT_W-1:0]   wr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    mtc_pkg::entry_t    cur_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    mtc_pkg::kind_t     kind_reg;
    mtc_pkg::kind_t     kind_next;
    logic [15:0]        oid_reg;
    logic [15:0]        oid_next;
    logic [7:0]         ohandler_reg;
    logic [7:0]         ohandler_next;
    logic [31:0]        oa_reg;
    logic [31:0]        oa_next;
    logic [31:0]        ob_reg;
    logic [31:0]        ob_next;
    logic               olast_reg;
    logic               olast_next;

    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    mtc_pkg::entry_t    tbl_wdata;

    mtc_pkg::entry_t    cur;
    mtc_pkg::entry_t    new_entry;
    logic [32:0]        diff;
    logic [31:0]        sat_cd;
    logic               id_match;
    logic               id_pos;
    logic               reload_pos;
    logic               keep;

    assign cur = cur_reg;

    // The entry for the next scan cycle is fetched into cur_reg ahead of its use.
    assign rd_ahead = cmd.load ? '0 : (rd_reg + IDX_W'(1));

    assign status.zero_id     = (mtc_pkg::func_t'(func) != mtc_pkg::FUNC_TICK)
                                && (timer_id == 16'sd0);
    assign status.table_empty = (count_reg == '0);
    assign status.scan_last   = ({{(CNT_W-IDX_W){1'b0}}, rd_reg}
                                 == (count_reg - CNT_W'(1)));

    assign id_match   = (cur.id == id_reg);
    assign id_pos     = !cur.id[15] && (cur.id != 16'd0);
    assign reload_pos = !cur.reload[31] && (cur.reload != 32'd0);

    // Countdown minus elapsed time; a change of sign bit below means underflow.
    assign diff   = {cur.countdown[31], cur.countdown} - {17'd0, el_reg};
    assign sat_cd = (diff[32] != diff[31]) ? 32'h8000_0000 : diff[31:0];

    always_comb
    begin
        new_entry.id        = id_reg;
        new_entry.countdown = tv_reg;
        new_entry.reload    = per_reg ? tv_reg : 32'd0;
        new_entry.handler   = tag_reg;
        new_entry.arg_a     = a_reg;
        new_entry.arg_b     = b_reg;
    end

    always_comb
    begin
        keep           = 1'b1;
        tbl_we         = 1'b0;
        tbl_waddr      = wr_reg[IDX_W-1:0];
        tbl_wdata      = cur;
        found_next     = found_reg;
        wr_next        = wr_reg;
        count_next     = count_reg;
        out_valid_next = 1'b0;
        kind_next      = kind_reg;
        oid_next       = oid_reg;
        ohandler_next  = 8'd0;
        oa_next        = 32'd0;
        ob_next        = 32'd0;
        olast_next     = 1'b0;

        if (cmd.scan)
        begin
            case (func_reg)
                mtc_pkg::FUNC_TICK:
                begin
                    if (id_pos)
                    begin
                        tbl_wdata.countdown = sat_cd;
                        if (sat_cd[31] || (sat_cd == 32'd0))
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = mtc_pkg::KIND_FIRED;
                            oid_next       = cur.id;
                            ohandler_next  = cur.handler;
                            oa_next        = cur.arg_a;
                            ob_next        = cur.arg_b;
                            if (reload_pos)
                            begin
                                tbl_wdata.countdown = cur.reload;
                            end
                            else
                            begin
                                keep = 1'b0;
                            end
                        end
                    end
                end
                mtc_pkg::FUNC_ADD:
                begin
                    if (id_match)
                    begin
                        found_next = 1'b1;
                        tbl_wdata  = new_entry;
                    end
                end
                mtc_pkg::FUNC_DELETE:
                begin
                    if (id_match)
                    begin
                        found_next = 1'b1;
                        keep       = 1'b0;
                    end
                end
                mtc_pkg::FUNC_UPDATE:
                begin
                    if (id_match)
                    begin
                        found_next          = 1'b1;
                        tbl_wdata.countdown = tv_reg;
                        if (reload_pos)
                        begin
                            tbl_wdata.reload = tv_reg;
                        end
                    end
                end
                default:
                begin
                    keep = 1'b1;
                end
            endcase
            // Kept entries slide down to the write pointer, closing any gaps.
            if (keep)
            begin
                tbl_we  = 1'b1;
                wr_next = wr_reg + CNT_W'(1);
            end
        end
        else if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            olast_next     = 1'b1;
            oid_next       = id_reg;
            if (zero_reg)
            begin
                kind_next = mtc_pkg::KIND_ID_ZERO;
            end
            else
            begin
                count_next = wr_reg;
                case (func_reg)
                    mtc_pkg::FUNC_TICK:
                    begin
                        kind_next = mtc_pkg::KIND_TICK_DONE;
                        oid_next  = 16'd0;
                    end
                    mtc_pkg::FUNC_ADD:
                    begin
                        if (found_reg)
                        begin
                            kind_next = mtc_pkg::KIND_REPLACED;
                        end
                        else if (wr_reg == CNT_W'(mtc_pkg::TABLE_DEPTH))
                        begin
                            kind_next = mtc_pkg::KIND_FULL;
                        end
                        else
                        begin
                            kind_next  = mtc_pkg::KIND_ADDED;
                            tbl_we     = 1'b1;
                            tbl_wdata  = new_entry;
                            count_next = wr_reg + CNT_W'(1);
                        end
                    end
                    mtc_pkg::FUNC_DELETE:
                    begin
                        kind_next = found_reg ? mtc_pkg::KIND_DELETED
                                              : mtc_pkg::KIND_NOT_FOUND;
                    end
                    mtc_pkg::FUNC_UPDATE:
                    begin
                        kind_next = found_reg ? mtc_pkg::KIND_UPDATED
                                              : mtc_pkg::KIND_NOT_FOUND;
                    end
                    default:
                    begin
                        kind_next = mtc_pkg::KIND_NOT_FOUND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        // Writes only land at or below the entry being scanned, never on the one fetched.
        if (cmd.load || cmd.scan)
        begin
            cur_reg <= tbl_mem[rd_ahead];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= mtc_pkg::func_t'(func);
            id_reg   <= timer_id;
            tv_reg   <= time_value;
            per_reg  <= periodic;
            tag_reg  <= handler_tag;
            a_reg    <= arg_a;
            b_reg    <= arg_b;
            el_reg   <= elapsed_ms;
            zero_reg <= status.zero_id;
        end
        kind_reg     <= kind_next;
        oid_reg      <= oid_next;
        ohandler_reg <= ohandler_next;
        oa_reg       <= oa_next;
        ob_reg       <= ob_next;
        olast_reg    <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cmd.load)
            begin
                rd_reg    <= '0;
                wr_reg    <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_reg    <= rd_reg + IDX_W'(1);
                wr_reg    <= wr_next;
                found_reg <= found_next;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign kind          = kind_reg;
    assign fired_id      = oid_reg;
    assign fired_handler = ohandler_reg;
    assign fired_arg_a   = oa_reg;
    assign fired_arg_b   = ob_reg;
    assign last          = olast_reg;

endmodule

`default_nettype wire

[hw/rtl/multi_timer_countdown_table_core.sv]
// IDLE loads a word, SCAN visits each stored timer, FINISH ends it; every result is registered.
// A request on an empty table, or with id zero, skips SCAN and goes straight to FINISH.
// Throughput: one word at a time, set by the one-entry-per-cycle scan of the table.
// Results go out on a one-cycle strobe; the receiver cannot stall them.
// Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_countdown_table_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic signed [15:0]  timer_id,
    input  logic signed [31:0]  time_value,
    input  logic                periodic,
    input  logic [7:0]          handler_tag,
    input  logic signed [31:0]  arg_a,
    input  logic signed [31:0]  arg_b,
    input  logic [15:0]         elapsed_ms,
    output logic                result_valid,
    output logic [3:0]          kind,
    output logic signed [15:0]  fired_id,
    output logic [7:0]          fired_handler,
    output logic signed [31:0]  fired_arg_a,
    output logic signed [31:0]  fired_arg_b,
    output logic                last
);

    mtc_pkg::cmd_t    cmd;
    mtc_pkg::status_t status;

    mtc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mtc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .timer_id      (timer_id),
        .time_value    (time_value),
        .periodic      (periodic),
        .handler_tag   (handler_tag),
        .arg_a         (arg_a),
        .arg_b         (arg_b),
        .elapsed_ms    (elapsed_ms),
        .result_valid  (result_valid),
        .kind          (kind),
        .fired_id      (fired_id),
        .fired_handler (fired_handler),
        .fired_arg_a   (fired_arg_a),
        .fired_arg_b   (fired_arg_b),
        .last          (last)
    );

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.finish}))
        else $error("controller issued more than one command");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_fired_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("fired word seen after the request had finished");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final word seen while the block is still busy");
`endif

endmodule

`default_nettype wire
